>>> hdl/gnoise_pkg.sv
// Shared types and constants of the gradient noise block.
// No dependencies; imported by gradient_noise_1d_2d.
package gnoise_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = 8;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int GRAD_W     = 9;
    localparam int OUT_W      = 19;

    // Fold limit of the 1D coordinate: 255.0 in Q8.16
    localparam logic [23:0] FOLD_LIM = 24'hFF0000;

    typedef enum logic [1:0] {
        ACT_LOAD     = 2'd0,
        ACT_NOISE_1D = 2'd1,
        ACT_NOISE_2D = 2'd2
    } t_action;

    // Absolute value of a signed coordinate; the most negative value saturates.
    function automatic logic [COORD_W-2:0] abs_sat(input logic [COORD_W-1:0] c);
        logic [COORD_W-1:0] n;
        n = c[COORD_W-1] ? (~c + 1'b1) : c;
        return n[COORD_W-1] ? '1 : n[COORD_W-2:0];
    endfunction

endpackage

>>> hdl/gradient_noise_1d_2d.sv
// Top level of the fixed-point 1D/2D gradient noise block.
// Depends on gnoise_pkg and gnoise_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one beat per item: a table
//   load (action 0), a 1D noise item (action 1) or a 2D noise item (action 2).
//   Action 3 is dropped. Loads write one entry of every table and give no
//   result; each noise item gives one beat on the output channel
//   (o_out_valid / i_out_stall) with o_noise_value in signed Q3.16.
//   Load every table entry before a noise item reads it.
//   i_cfg_wr_en / i_cfg_wr_data set the fade curve (0 cubic, 1 quintic);
//   write it only while no item is in flight.
// Pipeline and throughput:
//   A result passes stages 1 to 8 and then the output register. One item is
//   accepted per cycle unless the output stalls: the eight-stage pipeline with
//   its table copies (each read at a single stage) sustains one item per clock.
// Reset (synchronous, active low) empties the pipeline and selects the cubic
//   fade; table contents are kept and are undefined until loaded.
// Stall: while a result waits and i_out_stall is high the whole pipeline
//   holds and o_in_stall is raised; nothing is lost or repeated.
module gradient_noise_1d_2d
    import gnoise_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_action,
    input  logic signed [COORD_W-1:0]  i_coord_x,
    input  logic signed [COORD_W-1:0]  i_coord_y,
    input  logic [IDX_W-1:0]           i_entry_index,
    input  logic [IDX_W-1:0]           i_perm_value,
    input  logic signed [GRAD_W-1:0]   i_grad_one_value,
    input  logic signed [GRAD_W-1:0]   i_grad_x_value,
    input  logic signed [GRAD_W-1:0]   i_grad_y_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [OUT_W-1:0]    o_noise_value
);

    function automatic logic signed [26:0] gdot(
        input logic [2*GRAD_W-1:0] g,
        input logic signed [16:0]  dx,
        input logic signed [16:0]  dy
    );
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        gx = $signed(g[GRAD_W-1:0]);
        gy = $signed(g[2*GRAD_W-1:GRAD_W]);
        return gx * dx + gy * dy;
    endfunction

    // ---------------- control ----------------
    logic adv;
    logic in_acc;
    logic r_fade_mode;

    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;
    assign in_acc     = i_in_valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_fade_mode <= i_cfg_wr_data;
        end
    end

    // per-stage flags: load beat, result-bearing beat, 2D item
    logic r_ld  [1:4];
    logic r_res [1:8];
    logic r_2d  [1:8];
    logic n_ld1, n_res1;

    assign n_ld1  = in_acc && (i_action == ACT_LOAD);
    assign n_res1 = in_acc && (i_action == ACT_NOISE_1D || i_action == ACT_NOISE_2D);

    // load payload, carried to the last table write stage
    logic [IDX_W-1:0]  r_idx  [1:4];
    logic [IDX_W-1:0]  r_perm [1:4];
    logic [GRAD_W-1:0] r_g1   [1:4];
    logic [GRAD_W-1:0] r_gx   [1:4];
    logic [GRAD_W-1:0] r_gy   [1:4];

    // ---------------- stage 1 -> 2: fold ----------------
    logic [COORD_W-2:0] r_s1_ax, r_s1_ay;
    logic [14:0]        x_int;
    logic [8:0]         fold_sum;
    logic [7:0]         fold_q;
    logic [23:0]        fold_val;
    logic [23:0]        n_x24;
    logic               fold_over;

    assign x_int     = r_s1_ax[COORD_W-2:FRAC_BITS];
    // 256 = 1 mod 255: add the two byte halves, then one subtract
    assign fold_sum  = {2'b0, x_int[14:8]} + {1'b0, x_int[7:0]};
    assign fold_q    = (fold_sum >= 9'd255) ? 8'(fold_sum - 9'd255) : fold_sum[7:0];
    assign fold_val  = FOLD_LIM - {fold_q, r_s1_ax[FRAC_BITS-1:0]};
    assign fold_over = r_s1_ax > {7'd0, FOLD_LIM};
    assign n_x24     = (r_2d[1] || !fold_over) ? r_s1_ax[23:0] : fold_val;

    // ---------------- stage 2: level-1 permutation, fade step 1 ----------------
    logic [IDX_W-1:0]     r_s2_xi, r_s2_yi;
    logic [FRAC_BITS-1:0] r_s2_fr [2];
    logic [IDX_W-1:0]     p1_addr [2];
    logic [IDX_W-1:0]     p1_rdata [2];
    logic [31:0]          sq [2];

    assign p1_addr[0] = r_2d[2] ? r_s2_yi : r_s2_xi;
    assign p1_addr[1] = r_2d[2] ? r_s2_yi + 8'd1 :
                        (r_s2_fr[0] != '0) ? r_s2_xi + 8'd1 : r_s2_xi;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            sq[k] = r_s2_fr[k] * r_s2_fr[k];
        end
    end

    // ---------------- stage 3: corner hash / 1D gradients, fade step 2 ----------------
    logic [IDX_W-1:0]     r_s3_xi;
    logic [FRAC_BITS-1:0] r_s3_fr [2];
    logic [15:0]          r_s3_t2 [2];
    logic [IDX_W-1:0]     xi_inc;
    logic [IDX_W-1:0]     p2_addr [4];
    logic [IDX_W-1:0]     p2_rdata [4];
    logic [GRAD_W-1:0]    g1_rdata [2];
    logic [31:0]          t3p [2];
    logic [17:0]          cub_m [2];
    logic [33:0]          cub_p [2];
    logic [19:0]          n_inner [2];

    assign xi_inc     = r_s3_xi + 8'd1;
    assign p2_addr[0] = r_s3_xi * p1_rdata[0];
    assign p2_addr[1] = xi_inc  * p1_rdata[0];
    assign p2_addr[2] = r_s3_xi * p1_rdata[1];
    assign p2_addr[3] = xi_inc  * p1_rdata[1];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            t3p[k]     = r_s3_t2[k] * r_s3_fr[k];
            cub_m[k]   = 18'd196608 - {1'b0, r_s3_fr[k], 1'b0};
            cub_p[k]   = r_s3_t2[k] * cub_m[k];
            n_inner[k] = ({4'd0, r_s3_t2[k]} * 20'd6) + 20'd655360
                       - ({4'd0, r_s3_fr[k]} * 20'd15);
        end
    end

    // ---------------- stage 4: 2D gradients, fade step 3 ----------------
    logic [FRAC_BITS-1:0] r_s4_fr [2];
    logic [15:0]          r_s4_t3 [2];
    logic [16:0]          r_s4_fc [2];
    logic [19:0]          r_s4_in [2];
    logic [35:0]          qp [2];
    logic [16:0]          n_f [2];
    logic [2*GRAD_W-1:0]  g2_rdata [4];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            qp[k]  = r_s4_t3[k] * r_s4_in[k];
            n_f[k] = r_fade_mode ? qp[k][32:16] : r_s4_fc[k];
        end
    end

    // ---------------- stage 5: corner dot products ----------------
    logic [FRAC_BITS-1:0]     r_s5_fr [2];
    logic [16:0]              r_s5_f  [2];
    logic signed [GRAD_W-1:0] r_s5_g1 [2];
    logic signed [16:0]       dxp, dxn, dyp, dyn, dr;
    logic signed [26:0]       n_d [4];

    assign dxp = $signed({1'b0, r_s5_fr[0]});
    assign dxn = $signed({1'b1, r_s5_fr[0]});   // frac - 1.0
    assign dyp = $signed({1'b0, r_s5_fr[1]});
    assign dyn = $signed({1'b1, r_s5_fr[1]});
    assign dr  = (r_s5_fr[0] != '0) ? dxn : 17'sd0;

    always_comb begin
        n_d[0] = r_2d[5] ? gdot(g2_rdata[0], dxp, dyp) : 27'(r_s5_g1[0] * dxp);
        n_d[1] = r_2d[5] ? gdot(g2_rdata[1], dxn, dyp) : 27'(r_s5_g1[1] * dr);
        n_d[2] = gdot(g2_rdata[2], dxp, dyn);
        n_d[3] = gdot(g2_rdata[3], dxn, dyn);
    end

    // ---------------- stage 6: blend along x ----------------
    logic signed [26:0] r_s6_d [4];
    logic [16:0]        r_s6_f [2];
    logic signed [17:0] fx, omx;
    logic signed [45:0] n_row [2];

    assign fx       = $signed({1'b0, r_s6_f[0]});
    assign omx      = 18'sh10000 - fx;
    assign n_row[0] = r_s6_d[0] * omx + r_s6_d[1] * fx;
    assign n_row[1] = r_s6_d[2] * omx + r_s6_d[3] * fx;

    // ---------------- stage 7: blend along y ----------------
    logic signed [45:0] r_s7_row [2];
    logic [16:0]        r_s7_fy;
    logic signed [17:0] fy, omy;
    logic signed [64:0] n_acc;

    assign fy    = $signed({1'b0, r_s7_fy});
    assign omy   = 18'sh10000 - fy;
    assign n_acc = r_2d[7] ? (r_s7_row[0] * omy + r_s7_row[1] * fy)
                           : 65'(r_s7_row[0]);

    // ---------------- stage 8: scale and saturate ----------------
    logic signed [64:0]      r_s8_acc;
    logic signed [64:0]      scaled;
    logic signed [OUT_W-1:0] n_out;
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_noise;

    assign scaled = r_2d[8] ? (r_s8_acc >>> 40) : (r_s8_acc >>> 24);

    always_comb begin
        if (scaled < -65'sd262144) begin
            n_out = {1'b1, {(OUT_W-1){1'b0}}};
        end else if (scaled > 65'sd262143) begin
            n_out = {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            n_out = scaled[OUT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_out_noise;

    // ---------------- flag registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 4; s++) begin
                r_ld[s] <= 1'b0;
            end
            for (int s = 1; s <= 8; s++) begin
                r_res[s] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_ld[1]  <= n_ld1;
            r_res[1] <= n_res1;
            for (int s = 2; s <= 4; s++) begin
                r_ld[s] <= r_ld[s-1];
            end
            for (int s = 2; s <= 8; s++) begin
                r_res[s] <= r_res[s-1];
            end
            r_out_valid <= r_res[8];
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_2d[1]   <= (i_action == ACT_NOISE_2D);
            r_idx[1]  <= i_entry_index;
            r_perm[1] <= i_perm_value;
            r_g1[1]   <= i_grad_one_value;
            r_gx[1]   <= i_grad_x_value;
            r_gy[1]   <= i_grad_y_value;
            for (int s = 2; s <= 8; s++) begin
                r_2d[s] <= r_2d[s-1];
            end
            for (int s = 2; s <= 4; s++) begin
                r_idx[s]  <= r_idx[s-1];
                r_perm[s] <= r_perm[s-1];
                r_g1[s]   <= r_g1[s-1];
                r_gx[s]   <= r_gx[s-1];
                r_gy[s]   <= r_gy[s-1];
            end

            r_s1_ax <= abs_sat(i_coord_x);
            r_s1_ay <= abs_sat(i_coord_y);

            r_s2_xi    <= n_x24[23:FRAC_BITS];
            r_s2_fr[0] <= n_x24[FRAC_BITS-1:0];
            r_s2_yi    <= r_s1_ay[FRAC_BITS+IDX_W-1:FRAC_BITS];
            r_s2_fr[1] <= r_s1_ay[FRAC_BITS-1:0];

            r_s3_xi <= r_s2_xi;
            for (int k = 0; k < 2; k++) begin
                r_s3_fr[k] <= r_s2_fr[k];
                r_s3_t2[k] <= sq[k][31:16];

                r_s4_fr[k] <= r_s3_fr[k];
                r_s4_t3[k] <= t3p[k][31:16];
                r_s4_fc[k] <= cub_p[k][32:16];
                r_s4_in[k] <= n_inner[k];

                r_s5_fr[k] <= r_s4_fr[k];
                r_s5_f[k]  <= n_f[k];
                r_s5_g1[k] <= $signed(g1_rdata[k]);

                r_s6_f[k]   <= r_s5_f[k];
                r_s7_row[k] <= n_row[k];
            end
            for (int j = 0; j < 4; j++) begin
                r_s6_d[j] <= n_d[j];
            end
            r_s7_fy     <= r_s6_f[1];
            r_s8_acc    <= n_acc;
            r_out_noise <= n_out;
        end
    end

    // ---------------- table copies, each written at its read stage ----------------
    for (genvar k = 0; k < 2; k++) begin : g_perm1
        gnoise_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_ram (
            .i_clk   (i_clk),
            .i_we    (adv && r_ld[2]),
            .i_waddr (r_idx[2]),
            .i_wdata (r_perm[2]),
            .i_re    (adv),
            .i_raddr (p1_addr[k]),
            .o_rdata (p1_rdata[k])
        );
    end

    for (genvar k = 0; k < 2; k++) begin : g_gone
        gnoise_ram #(.WIDTH(GRAD_W), .DEPTH(TABLE_SIZE)) u_ram (
            .i_clk   (i_clk),
            .i_we    (adv && r_ld[3]),
            .i_waddr (r_idx[3]),
            .i_wdata (r_g1[3]),
            .i_re    (adv),
            .i_raddr (p1_rdata[k]),
            .o_rdata (g1_rdata[k])
        );
    end

    for (genvar k = 0; k < 4; k++) begin : g_perm2
        gnoise_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_ram (
            .i_clk   (i_clk),
            .i_we    (adv && r_ld[3]),
            .i_waddr (r_idx[3]),
            .i_wdata (r_perm[3]),
            .i_re    (adv),
            .i_raddr (p2_addr[k]),
            .o_rdata (p2_rdata[k])
        );
    end

    for (genvar k = 0; k < 4; k++) begin : g_gtwo
        gnoise_ram #(.WIDTH(2*GRAD_W), .DEPTH(TABLE_SIZE)) u_ram (
            .i_clk   (i_clk),
            .i_we    (adv && r_ld[4]),
            .i_waddr (r_idx[4]),
            .i_wdata ({r_gy[4], r_gx[4]}),
            .i_re    (adv),
            .i_raddr (p2_rdata[k]),
            .o_rdata (g2_rdata[k])
        );
    end

`ifndef NO_ASSERTIONS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_noise_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_action == ACT_NOISE_1D || i_action == ACT_NOISE_2D)) |=> r_res[1])
        else $error("accepted noise beat lost at pipeline entry");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> (r_res[8] == $past(r_res[8]) && r_ld[4] == $past(r_ld[4])))
        else $error("pipeline moved while held");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ld[4] |-> !r_res[4])
        else $error("load beat marked as result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
`endif

endmodule

>>> hdl/gnoise_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced for every table copy of the noise block.
module gnoise_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
